@@ design/dtov_pkg.sv @@
// Shared types and constants for the definite-time overvoltage relay.
package dtov_pkg;

    localparam int TIME_W       = 40;
    localparam int DELAY_W      = 32;
    localparam int VOLT_W       = 16;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int INPUT_PHASES = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALARM_LIMIT = 2'd0,
        CFG_ALARM_DELAY = 2'd1,
        CFG_TRIP_LIMIT  = 2'd2,
        CFG_TRIP_DELAY  = 2'd3
    } dtov_cfg_idx_t;

    typedef struct packed {
        logic [VOLT_W-1:0]  alarm_limit;
        logic [DELAY_W-1:0] alarm_delay;
        logic [VOLT_W-1:0]  trip_level;
        logic [DELAY_W-1:0] trip_delay;
    } dtov_cfg_t;

    typedef struct packed {
        logic trip_hit;
        logic alarm_hit;
    } dtov_phase_res_t;

    localparam logic [VOLT_W-1:0]  ALARM_LIMIT_RST = 16'hFFFF;
    localparam logic [DELAY_W-1:0] ALARM_DELAY_RST = 32'd1000;
    localparam logic [VOLT_W-1:0]  TRIP_LIMIT_RST  = 16'hFFFF;
    localparam logic [DELAY_W-1:0] TRIP_DELAY_RST  = 32'd1000;

endpackage

@@ design/dtov_cfg.sv @@
// Configuration register file: limits and delays.
module dtov_cfg
    import dtov_pkg::*;
#(
    parameter int VOLTAGE_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output dtov_cfg_t             cfg
);

    localparam int VW = (VOLTAGE_WIDTH < VOLT_W) ? VOLTAGE_WIDTH : VOLT_W;
    localparam logic [VOLT_W-1:0] VOLT_MASK = VOLT_W'((17'd1 << VW) - 17'd1);

    dtov_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alarm_limit <= ALARM_LIMIT_RST & VOLT_MASK;
            cfg_reg.alarm_delay <= ALARM_DELAY_RST;
            cfg_reg.trip_level  <= TRIP_LIMIT_RST & VOLT_MASK;
            cfg_reg.trip_delay  <= TRIP_DELAY_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ALARM_LIMIT: cfg_reg.alarm_limit <= cfg_data[VOLT_W-1:0] & VOLT_MASK;
                CFG_ALARM_DELAY: cfg_reg.alarm_delay <= cfg_data[DELAY_W-1:0];
                CFG_TRIP_LIMIT:  cfg_reg.trip_level  <= cfg_data[VOLT_W-1:0] & VOLT_MASK;
                CFG_TRIP_DELAY:  cfg_reg.trip_delay  <= cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/dtov_phase.sv @@
// One phase: trip and alarm timers with their band compares.
module dtov_phase
    import dtov_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              upd,
    input  logic [TIME_W-1:0] now,
    input  logic [VOLT_W-1:0] volt,
    input  dtov_cfg_t         cfg,
    output dtov_phase_res_t   res
);

    logic              trip_timing_reg, trip_timing_next;
    logic              alarm_timing_reg, alarm_timing_next;
    logic [TIME_W-1:0] trip_start_reg, trip_start_next;
    logic [TIME_W-1:0] alarm_start_reg, alarm_start_next;

    logic              over, band;
    logic [TIME_W-1:0] trip_elapsed, alarm_elapsed;

    always_comb begin
        over = volt > cfg.trip_level;
        band = !over && (volt >= cfg.alarm_limit);
        // elapsed time wraps modulo the timestamp width
        trip_elapsed  = now - trip_start_reg;
        alarm_elapsed = now - alarm_start_reg;

        res.trip_hit  = over && trip_timing_reg &&
                        (trip_elapsed >= TIME_W'(cfg.trip_delay));
        res.alarm_hit = band && alarm_timing_reg &&
                        (alarm_elapsed >= TIME_W'(cfg.alarm_delay));

        trip_timing_next  = trip_timing_reg;
        alarm_timing_next = alarm_timing_reg;
        trip_start_next   = trip_start_reg;
        alarm_start_next  = alarm_start_reg;
        if (over) begin
            if (!trip_timing_reg) begin
                trip_timing_next = 1'b1;
                trip_start_next  = now;
            end
        end else if (band) begin
            trip_timing_next = 1'b0;
            if (!alarm_timing_reg) begin
                alarm_timing_next = 1'b1;
                alarm_start_next  = now;
            end
        end else begin
            trip_timing_next  = 1'b0;
            alarm_timing_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trip_timing_reg  <= 1'b0;
            alarm_timing_reg <= 1'b0;
        end else if (upd) begin
            trip_timing_reg  <= trip_timing_next;
            alarm_timing_reg <= alarm_timing_next;
        end
    end

    // start times are only looked at while their running bit is set
    always_ff @(posedge aclk) begin
        if (upd) begin
            trip_start_reg  <= trip_start_next;
            alarm_start_reg <= alarm_start_next;
        end
    end

endmodule

@@ design/definite_time_overvoltage_relay.sv @@
// Definite-time overvoltage relay top level: input register, phase chain, result register.
// Takes one word per clock and returns one result word per input word, through the input
// register and then the result register, with no gaps while m_ready stays high. The cycle
// is set by each phase's 40-bit elapsed-time subtract and delay compare, followed by the
// A-to-C trip skip chain; timer state is updated when the result is registered, so the
// next word sees it. Configuration writes take effect on the next clock and must be made
// while no word is in flight. No clearing pass after reset.
module definite_time_overvoltage_relay
    import dtov_pkg::*;
#(
    parameter int PHASE_COUNT   = 3,
    parameter int VOLTAGE_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [TIME_W-1:0]     s_now,
    input  logic [VOLT_W-1:0]     s_phase_a,
    input  logic [VOLT_W-1:0]     s_phase_b,
    input  logic [VOLT_W-1:0]     s_phase_c,
    input  logic                  s_breaker_closed,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_trip,
    output logic [INPUT_PHASES-1:0] m_alarm_mask,
    output logic                  m_evaluated
);

    localparam int VW = (VOLTAGE_WIDTH < VOLT_W) ? VOLTAGE_WIDTH : VOLT_W;
    localparam logic [VOLT_W-1:0] VOLT_MASK = VOLT_W'((17'd1 << VW) - 17'd1);
    localparam int MASK_PHASES = (PHASE_COUNT < INPUT_PHASES) ? PHASE_COUNT : INPUT_PHASES;

    dtov_cfg_t cfg;

    logic                  in_valid_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [VOLT_W-1:0]     volt_reg [INPUT_PHASES];
    logic                  closed_reg;

    logic                  out_valid_reg;
    logic                  trip_reg, trip_next;
    logic [INPUT_PHASES-1:0] mask_reg, mask_next;
    logic                  eval_reg;

    logic                  adv;
    logic [PHASE_COUNT:0]  go;
    dtov_phase_res_t       res [PHASE_COUNT];
    logic [VOLT_W-1:0]     volt [PHASE_COUNT];

    dtov_cfg #(.VOLTAGE_WIDTH(VOLTAGE_WIDTH)) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // result register frees up when empty or being taken
    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            now_reg     <= s_now;
            volt_reg[0] <= s_phase_a & VOLT_MASK;
            volt_reg[1] <= s_phase_b & VOLT_MASK;
            volt_reg[2] <= s_phase_c & VOLT_MASK;
            closed_reg  <= s_breaker_closed;
        end
    end

    // a tripping phase stops evaluation of the phases after it
    assign go[0] = closed_reg;

    for (genvar i = 0; i < PHASE_COUNT; i++) begin : g_phase
        if (i < INPUT_PHASES) begin : g_in
            assign volt[i] = volt_reg[i];
        end else begin : g_pad
            assign volt[i] = '0;
        end

        dtov_phase u_phase (
            .aclk    (aclk),
            .aresetn (aresetn),
            .upd     (adv && go[i]),
            .now     (now_reg),
            .volt    (volt[i]),
            .cfg     (cfg),
            .res     (res[i])
        );

        assign go[i+1] = go[i] && !res[i].trip_hit;
    end

    always_comb begin
        trip_next = 1'b0;
        mask_next = '0;
        for (int i = 0; i < PHASE_COUNT; i++) begin
            if (go[i] && res[i].trip_hit) begin
                trip_next = 1'b1;
            end
        end
        for (int i = 0; i < MASK_PHASES; i++) begin
            mask_next[i] = go[i] && res[i].alarm_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            trip_reg <= trip_next;
            mask_reg <= mask_next;
            eval_reg <= closed_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_trip       = trip_reg;
    assign m_alarm_mask = mask_reg;
    assign m_evaluated  = eval_reg;

endmodule

@@ design/dtov_checker.sv @@
// Port-level checks for the overvoltage relay, bound to the top level.
module dtov_checker
    import dtov_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic                    m_trip,
    input logic [INPUT_PHASES-1:0] m_alarm_mask,
    input logic                    m_evaluated
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_trip) &&
        $stable(m_alarm_mask) && $stable(m_evaluated))
        else $error("result word changed while stalled");

    // an open breaker word carries no trip and no alarm
    a_open_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_evaluated |-> !m_trip && m_alarm_mask == '0)
        else $error("trip or alarm on an unevaluated word");

    // input only backs up behind a stalled result
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with result side free");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule

bind definite_time_overvoltage_relay dtov_checker u_dtov_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_trip           (m_trip),
    .m_alarm_mask     (m_alarm_mask),
    .m_evaluated      (m_evaluated)
);

@@ verif/definite_time_overvoltage_relay_tb.sv @@
// Self-checking testbench for the definite-time overvoltage relay: directed and random words.
module definite_time_overvoltage_relay_tb
    import dtov_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [TIME_W-1:0]                   now;
        logic [INPUT_PHASES-1:0][VOLT_W-1:0] volts;   // [0] is phase A
        logic                                closed;
    } relay_word_t;

    typedef struct packed {
        logic                    trip;
        logic [INPUT_PHASES-1:0] alarm_mask;
        logic                    evaluated;
    } verdict_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [TIME_W-1:0]       s_now = '0;
    logic [VOLT_W-1:0]       s_phase_a = '0;
    logic [VOLT_W-1:0]       s_phase_b = '0;
    logic [VOLT_W-1:0]       s_phase_c = '0;
    logic                    s_breaker_closed = 1'b0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_trip;
    logic [INPUT_PHASES-1:0] m_alarm_mask;
    logic                    m_evaluated;

    definite_time_overvoltage_relay uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_now           (s_now),
        .s_phase_a       (s_phase_a),
        .s_phase_b       (s_phase_b),
        .s_phase_c       (s_phase_c),
        .s_breaker_closed(s_breaker_closed),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_trip          (m_trip),
        .m_alarm_mask    (m_alarm_mask),
        .m_evaluated     (m_evaluated)
    );

    always #4 aclk = ~aclk;

    // relay settings and per-phase timers as the predictor sees them
    logic [VOLT_W-1:0]  alarm_lim_q;
    logic [DELAY_W-1:0] alarm_dly_q;
    logic [VOLT_W-1:0]  trip_lim_q;
    logic [DELAY_W-1:0] trip_dly_q;
    logic [TIME_W-1:0]  trip_t0   [INPUT_PHASES];
    bit                 trip_run  [INPUT_PHASES];
    logic [TIME_W-1:0]  alarm_t0  [INPUT_PHASES];
    bit                 alarm_run [INPUT_PHASES];

    verdict_t verdict_q[$];
    verdict_t want;
    bit       no_idle = 1'b0;
    int       ready_hold = 0;
    int       errors = 0;
    int       words_sent = 0;
    int       verdicts_checked = 0;
    int       trips_seen = 0;
    int       alarm_bits_seen = 0;

    function automatic verdict_t relay_eval(input relay_word_t w);
        verdict_t          r;
        logic [TIME_W-1:0] el;
        bit                stop;
        r = '0;
        stop = 1'b0;
        r.evaluated = w.closed;
        if (w.closed) begin
            for (int i = 0; i < INPUT_PHASES; i++) begin
                if (!stop) begin
                    if (w.volts[i] > trip_lim_q) begin
                        if (!trip_run[i]) begin
                            trip_run[i] = 1'b1;
                            trip_t0[i]  = w.now;
                        end else begin
                            el = w.now - trip_t0[i];
                            if (el >= {8'd0, trip_dly_q}) begin
                                r.trip = 1'b1;
                                stop   = 1'b1;   // later phases not looked at
                            end
                        end
                    end else if (w.volts[i] >= alarm_lim_q) begin
                        trip_run[i] = 1'b0;
                        if (!alarm_run[i]) begin
                            alarm_run[i] = 1'b1;
                            alarm_t0[i]  = w.now;
                        end else begin
                            el = w.now - alarm_t0[i];
                            if (el >= {8'd0, alarm_dly_q})
                                r.alarm_mask[i] = 1'b1;
                        end
                    end else begin
                        alarm_run[i] = 1'b0;
                        trip_run[i]  = 1'b0;
                    end
                end
            end
        end
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    function automatic relay_word_t make_word(logic [TIME_W-1:0] now, logic [VOLT_W-1:0] a,
                                              logic [VOLT_W-1:0] b, logic [VOLT_W-1:0] c,
                                              logic closed);
        relay_word_t w;
        w.now      = now;
        w.volts[0] = a;
        w.volts[1] = b;
        w.volts[2] = c;
        w.closed   = closed;
        return w;
    endfunction

    // voltage relative to the current limits: below, band, over, edge or anything
    function automatic logic [VOLT_W-1:0] pick_volt(int kind);
        int al;
        int tl;
        al = int'(alarm_lim_q);
        tl = int'(trip_lim_q);
        case (kind)
            0: return (al == 0) ? '0 : VOLT_W'($urandom_range(0, al - 1));
            1: return VOLT_W'($urandom_range(al, tl));
            2: return (tl == 65535) ? 16'hFFFF : VOLT_W'($urandom_range(tl + 1, 65535));
            3: begin
                case ($urandom_range(0, 5))
                    0: return alarm_lim_q;
                    1: return trip_lim_q;
                    2: return VOLT_W'(tl + 1);
                    3: return VOLT_W'(al - 1);
                    4: return '0;
                    default: return 16'hFFFF;
                endcase
            end
            default: return VOLT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_word(input relay_word_t w);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_now            <= w.now;
        s_phase_a        <= w.volts[0];
        s_phase_b        <= w.volts[1];
        s_phase_c        <= w.volts[2];
        s_breaker_closed <= w.closed;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        verdict_q = {verdict_q, relay_eval(w)};
        words_sent++;
    endtask

    // stop sending and let every outstanding word come back
    task automatic drain();
        s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(dtov_cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        case (idx)
            CFG_ALARM_LIMIT: alarm_lim_q = d[VOLT_W-1:0];
            CFG_ALARM_DELAY: alarm_dly_q = d;
            CFG_TRIP_LIMIT:  trip_lim_q  = d[VOLT_W-1:0];
            CFG_TRIP_DELAY:  trip_dly_q  = d;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic load_settings(logic [VOLT_W-1:0] al, logic [DELAY_W-1:0] ad,
                                 logic [VOLT_W-1:0] tl, logic [DELAY_W-1:0] td);
        drain();
        write_reg(CFG_ALARM_LIMIT, CFG_DATA_W'(al));
        write_reg(CFG_ALARM_DELAY, ad);
        write_reg(CFG_TRIP_LIMIT, CFG_DATA_W'(tl));
        write_reg(CFG_TRIP_DELAY, td);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_reset_settings();
        send_word(make_word(40'd0, 16'd0, 16'd0, 16'd0, 1'b1));
        send_word(make_word(40'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        // at the trip limit counts as alarm band
        send_word(make_word(40'd10, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send_word(make_word(40'd1010, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send_word(make_word(40'd1011, 16'hFFFE, 16'd0, 16'hFFFF, 1'b1));
    endtask

    task automatic test_phase_order();
        load_settings(16'd100, 32'd10, 16'd200, 32'd20);
        send_word(make_word(40'd0, 16'd300, 16'd150, 16'd50, 1'b1));
        send_word(make_word(40'd10, 16'd300, 16'd150, 16'd200, 1'b1));
        // A trips, B and C skipped
        send_word(make_word(40'd25, 16'd300, 16'd150, 16'd200, 1'b1));
        send_word(make_word(40'd26, 16'd300, 16'd150, 16'd200, 1'b0));
        send_word(make_word(40'd30, 16'd150, 16'd300, 16'd0, 1'b1));
        send_word(make_word(40'd31, 16'd50, 16'd300, 16'hFFFF, 1'b1));
        send_word(make_word(40'd60, 16'd50, 16'd300, 16'hFFFF, 1'b1));
        send_word(make_word(40'd61, 16'd300, 16'd0, 16'hFFFF, 1'b1));
        send_word(make_word(40'd90, 16'd99, 16'd100, 16'd201, 1'b1));
    endtask

    task automatic test_crossed_limits();
        // alarm limit above trip limit: no alarm band at all
        load_settings(16'd500, 32'd0, 16'd100, 32'd0);
        send_word(make_word(40'd100, 16'd50, 16'd100, 16'd600, 1'b1));
        send_word(make_word(40'd101, 16'd50, 16'd100, 16'd600, 1'b1));
        send_word(make_word(40'd102, 16'd0, 16'd499, 16'hFFFF, 1'b1));
    endtask

    task automatic test_delay_extremes();
        load_settings(16'd100, 32'hFFFF_FFFF, 16'd200, 32'hFFFF_FFFF);
        send_word(make_word(40'd0, 16'd300, 16'd150, 16'd0, 1'b1));
        send_word(make_word(40'hFFFF_FFFE, 16'd300, 16'd150, 16'd0, 1'b1));
        send_word(make_word(40'hFFFF_FFFF, 16'd300, 16'd150, 16'd0, 1'b1));
        send_word(make_word(40'h1_0000_0000, 16'd0, 16'd150, 16'd0, 1'b1));
    endtask

    task automatic test_time_wrap();
        load_settings(16'd100, 32'd16, 16'd200, 32'd16);
        send_word(make_word(40'hFF_FFFF_FFF8, 16'd300, 16'd150, 16'd0, 1'b1));
        send_word(make_word(40'h00_0000_0008, 16'd300, 16'd150, 16'd0, 1'b1));
        // time steps backwards
        send_word(make_word(40'h00_0000_0004, 16'd0, 16'd150, 16'd0, 1'b1));
        send_word(make_word(40'h00_0000_0000, 16'd0, 16'd150, 16'd0, 1'b1));
    endtask

    // runs of steady levels per phase so the timers get to expire
    task automatic random_run(int n, int step_max, bit quiet, bit pause_mid);
        int                kind [INPUT_PHASES];
        relay_word_t       w;
        logic [TIME_W-1:0] now;
        int                r;
        no_idle = quiet;
        now = {8'($urandom_range(0, 255)), 32'($urandom)};
        for (int p = 0; p < INPUT_PHASES; p++)
            kind[p] = $urandom_range(0, 4);
        for (int k = 0; k < n; k++) begin
            if (pause_mid && k == n / 2)
                drain();
            r = $urandom_range(0, 99);
            if (r < 2)
                now = now - $urandom_range(1, 50);
            else if (r < 5)
                now = now + {8'd0, 32'($urandom)};
            else
                now = now + $urandom_range(0, step_max);
            w.now = now;
            for (int p = 0; p < INPUT_PHASES; p++) begin
                if ($urandom_range(0, 7) == 0)
                    kind[p] = $urandom_range(0, 4);
                w.volts[p] = pick_volt(kind[p]);
            end
            w.closed = ($urandom_range(0, 9) != 0);
            send_word(w);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        int al;
        load_settings(16'd1000, 32'd20, 16'd3000, 32'd40);
        random_run(140, 8, 1'b0, 1'b0);
        load_settings(16'd0, 32'd0, 16'd0, 32'd0);
        random_run(100, 3, 1'b1, 1'b0);
        load_settings(16'd40000, 32'hFFFF_FFFF, 16'd50000, 32'hFFFF_FFFF);
        random_run(100, 1 << 29, 1'b0, 1'b0);
        load_settings(16'd30000, 32'd5, 16'd20000, 32'd10);
        random_run(100, 4, 1'b0, 1'b1);
        repeat (3) begin
            al = $urandom_range(0, 65535);
            load_settings(VOLT_W'(al), $urandom_range(0, 60),
                          VOLT_W'($urandom_range(al, 65535)), $urandom_range(0, 60));
            random_run(60, 10, 1'b0, 1'b0);
        end
        load_settings(16'hFFFF, 32'd1000, 16'hFFFF, 32'd1000);
        random_run(60, 300, 1'b0, 1'b0);
    endtask

    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            ready_hold <= pick_gap();
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic compare_field(string name, logic [3:0] exp_v, logic [3:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t ns: result word with nothing expected (trip %0b mask %03b eval %0b)",
                         $time, m_trip, m_alarm_mask, m_evaluated);
                errors++;
            end else begin
                want = verdict_q.pop_front();
                compare_field("trip", 4'(want.trip), 4'(m_trip));
                compare_field("alarm_mask", 4'(want.alarm_mask), 4'(m_alarm_mask));
                compare_field("evaluated", 4'(want.evaluated), 4'(m_evaluated));
                verdicts_checked++;
                trips_seen      += int'(want.trip);
                alarm_bits_seen += $countones(want.alarm_mask);
            end
        end
    end

    initial begin
        alarm_lim_q = ALARM_LIMIT_RST;
        alarm_dly_q = ALARM_DELAY_RST;
        trip_lim_q  = TRIP_LIMIT_RST;
        trip_dly_q  = TRIP_DELAY_RST;
        for (int p = 0; p < INPUT_PHASES; p++) begin
            trip_run[p]  = 1'b0;
            alarm_run[p] = 1'b0;
            trip_t0[p]   = '0;
            alarm_t0[p]  = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_settings();
        test_phase_order();
        test_crossed_limits();
        test_delay_extremes();
        test_time_wrap();
        test_random_traffic();
        drain();
        repeat (8) @(posedge aclk);
        $display("Sent %0d words, checked %0d results: %0d trips and %0d alarm bits expected,",
                 words_sent, verdicts_checked, trips_seen, alarm_bits_seen);
        $display("over reset, crossed, zero and maximum settings with time wrap and stalls.");
        if (errors == 0 && verdict_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #5ms;
        $display("Timed out with %0d results outstanding", verdict_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
design/dtov_pkg.sv
design/dtov_cfg.sv
design/dtov_phase.sv
design/definite_time_overvoltage_relay.sv
design/dtov_checker.sv
verif/definite_time_overvoltage_relay_tb.sv
